>>> design/gdad_pkg.sv
// Shared types, constants and the control store for the Gregorian date-add unit.
// Holds the request and result payload types and the microcode table.
// Used by gdad_seq, gdad_dp and gregorian_date_add_days_unit.
package gdad_pkg;

  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [15:0] days_to_add;
  } req_t;

  typedef struct packed {
    logic [4:0]  end_day;
    logic [3:0]  end_month;
    logic [13:0] end_year;
    logic        start_invalid;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_CHECK,
    OP_MONTH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_INVALID,
    COND_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef logic [2:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic invalid;
    logic more;
    logic out_busy;
  } status_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_SETTLE = 3'd1;
  localparam step_t STEP_CHECK  = 3'd2;
  localparam step_t STEP_MONTH  = 3'd3;
  localparam step_t STEP_EMIT   = 3'd4;
  localparam step_t STEP_RETURN = 3'd5;

  // Year / 100 is taken as (year * LEAP_RECIP) >> LEAP_SHIFT, exact for 14-bit years.
  localparam logic [16:0] LEAP_RECIP = 17'd5243;
  localparam int          LEAP_SHIFT = 19;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;
  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [6:0]  CENTURY    = 7'd100;

  function automatic ctrl_word_t ucode(input step_t s);
    ctrl_word_t w;
    unique case (s)
      STEP_IDLE:   w = '{op: OP_LOAD,  cond: COND_NO_REQ,   target: STEP_IDLE};
      STEP_SETTLE: w = '{op: OP_NOP,   cond: COND_NEXT,     target: STEP_IDLE};
      STEP_CHECK:  w = '{op: OP_CHECK, cond: COND_INVALID,  target: STEP_EMIT};
      STEP_MONTH:  w = '{op: OP_MONTH, cond: COND_MORE,     target: STEP_MONTH};
      STEP_EMIT:   w = '{op: OP_EMIT,  cond: COND_OUT_BUSY, target: STEP_EMIT};
      STEP_RETURN: w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: STEP_IDLE};
      default:     w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    unique case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

>>> design/gdad_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on gdad_pkg for the control word, status and step constants.
module gdad_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  gdad_pkg::status_t status,
  output logic              req_stall,
  output gdad_pkg::op_t     op
);

  gdad_pkg::step_t      upc;
  gdad_pkg::step_t      upc_next;
  gdad_pkg::ctrl_word_t cw;
  logic                 take;

  always_comb begin
    cw = gdad_pkg::ucode(upc);
    unique case (cw.cond)
      gdad_pkg::COND_NEXT:     take = 1'b0;
      gdad_pkg::COND_ALWAYS:   take = 1'b1;
      gdad_pkg::COND_NO_REQ:   take = !req_valid;
      gdad_pkg::COND_INVALID:  take = status.invalid;
      gdad_pkg::COND_MORE:     take = status.more;
      gdad_pkg::COND_OUT_BUSY: take = status.out_busy;
      default:                 take = 1'b0;
    endcase
    upc_next = take ? cw.target : gdad_pkg::step_t'(upc + 3'd1);
  end

  always_comb begin
    op        = cw.op;
    req_stall = (upc != gdad_pkg::STEP_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= gdad_pkg::STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

>>> design/gdad_dp.sv
// Datapath for the date-add unit: date and count registers, leap logic and result register.
// Depends on gdad_pkg for payload types, operations and month lengths.
module gdad_dp (
  input  logic              clk,
  input  logic              rst,
  input  gdad_pkg::op_t     op,
  input  gdad_pkg::req_t    req,
  input  logic              rsp_stall,
  output gdad_pkg::status_t status,
  output logic              rsp_valid,
  output gdad_pkg::rsp_t    rsp
);

  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [15:0] n;
  logic [7:0]  q;
  logic        bad;

  logic [26:0] prod;
  logic [13:0] hundreds;
  logic        r_zero;
  logic        leap;
  logic [4:0]  dim;
  logic [16:0] day_plus_n;
  logic        fits;
  logic        out_busy;

  always_comb begin
    prod       = 27'(year) * 27'(gdad_pkg::LEAP_RECIP);
    hundreds   = 14'(15'(q) * 15'(gdad_pkg::CENTURY));
    r_zero     = (year == hundreds);
    leap       = ((year[1:0] == 2'd0) && !r_zero) || (r_zero && (q[1:0] == 2'd0));
    dim        = gdad_pkg::month_days(month, leap);
    day_plus_n = 17'(day) + 17'(n);
    fits       = (day_plus_n <= 17'(dim));
    out_busy   = rsp_valid && rsp_stall;
    status.invalid  = (year == 14'd0) || (month == 4'd0) || (month > gdad_pkg::MONTH_DEC)
                      || (day == 5'd0) || (day > dim);
    status.more     = (n != 16'd0) && !fits;
    status.out_busy = out_busy;
  end

  // The quotient is registered from the year and catches up in the cycle after a year change;
  // the month after a year change is January, whose length does not depend on it.
  always_ff @(posedge clk) begin
    q <= prod[gdad_pkg::LEAP_SHIFT +: 8];
    unique case (op)
      gdad_pkg::OP_LOAD: begin
        day   <= req.start_day;
        month <= req.start_month;
        year  <= req.start_year;
        n     <= req.days_to_add;
      end
      gdad_pkg::OP_CHECK: begin
        bad <= status.invalid;
      end
      gdad_pkg::OP_MONTH: begin
        if (n != 16'd0) begin
          if (fits) begin
            day <= day_plus_n[4:0];
            n   <= 16'd0;
          end else begin
            n   <= n - (16'(dim) - 16'(day) + 16'd1);
            day <= 5'd1;
            if (month == gdad_pkg::MONTH_DEC) begin
              month <= gdad_pkg::MONTH_JAN;
              year  <= year + 14'd1;
            end else begin
              month <= month + 4'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((op == gdad_pkg::OP_EMIT) && !out_busy) begin
      rsp <= '{end_day: day, end_month: month, end_year: year, start_invalid: bad};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((op == gdad_pkg::OP_EMIT) && !out_busy) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

>>> design/gregorian_date_add_days_unit.sv
// Top level of the Gregorian date-add unit: a microcoded sequencer driving the datapath.
// Depends on gdad_pkg, gdad_seq and gdad_dp.
//
//   channel  direction  payload          handshake
//   request  in         gdad_pkg::req_t  req_valid / req_stall
//   result   out        gdad_pkg::rsp_t  rsp_valid / rsp_stall
//
// After a request is accepted and loaded, the sequencer runs its settle and check steps,
// then its month step, which crosses one month boundary per cycle and adds the last days
// as it leaves, and then its emit step, which stores the result; an invalid start date
// goes from check straight to emit. The return step follows before the next request is
// taken; one request is in work at a time. The result register frees the sequencer once
// the result is stored; rsp_stall holds it at emit only while a previous result waits.
// Reset is synchronous and clears the step counter and the result valid flag.
module gregorian_date_add_days_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  gdad_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output gdad_pkg::rsp_t rsp
);

  gdad_pkg::op_t     op;
  gdad_pkg::status_t status;

  gdad_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .status    (status),
    .req_stall (req_stall),
    .op        (op)
  );

  gdad_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .req       (req),
    .rsp_stall (rsp_stall),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule
